[src/q5k_pkg.sv]
// Shared types, constants and float32 helpers for the Q5_K super-block dequantizer.
// Used by q5k_ctrl, q5k_dpath and q5k_superblock_dequantizer; depends on nothing else.
package q5k_pkg;

	localparam int BLOCK_WEIGHTS = 256;
	localparam int SCALE_BYTES   = 12;
	localparam int HIGH_BYTES    = 32;
	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

	typedef enum logic [1:0] {
		ACT_HEADER = 2'd0,
		ACT_SCALE  = 2'd1,
		ACT_HIGH   = 2'd2,
		ACT_QUANT  = 2'd3
	} action_t;

	// which packed scale byte the read port fetches for the current sub-block
	typedef enum logic [1:0] {
		RSEL_A,
		RSEL_B,
		RSEL_C
	} rsel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL_D,
		OP_MUL_M,
		OP_MUL_Q,
		OP_ADD_PRE,
		OP_ADD_POST
	} op_t;

	typedef struct packed {
		logic  sc_re;
		rsel_t rsel;
		logic  cap_hb;
		logic  cap_a;
		logic  cap_b;
		logic  cap_c;
		op_t   op;
		logic  half;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef struct packed {
		logic        special;
		logic [31:0] special_val;
		logic        sign;
		logic [7:0]  expo;
		logic [27:0] sum;
	} add_pre_t;

	// widen an fp16 pattern to float32, exactly
	function automatic logic [31:0] half_to_f32(input logic [15:0] h);
		logic        s;
		logic [4:0]  ex;
		logic [10:0] f;
		logic [7:0]  e32;
		logic [31:0] r;
		s  = h[15];
		ex = h[14:10];
		f  = {1'b0, h[9:0]};
		e32 = 8'd113;
		if (ex == 5'd0) begin
			if (f == 11'd0) begin
				r = {s, 31'b0};
			end else begin
				for (int i = 0; i < 10; i++) begin
					if (!f[10]) begin
						f   = f << 1;
						e32 = e32 - 8'd1;
					end
				end
				r = {s, e32, f[9:0], 13'b0};
			end
		end else if (ex == 5'h1F) begin
			r = {s, 8'hFF, h[9:0], 13'b0};
		end else begin
			r = {s, {3'b0, ex} + 8'd112, h[9:0], 13'b0};
		end
		return r;
	endfunction

	// small unsigned integer to float32 (always exact)
	function automatic logic [31:0] u6_to_f32(input logic [5:0] v);
		logic [2:0]  p;
		logic [28:0] m;
		logic [31:0] r;
		p = 3'd0;
		for (int i = 0; i < 6; i++) begin
			if (v[i]) p = 3'(i);
		end
		m = {23'b0, v} << (5'd23 - {2'b0, p});
		if (v == 6'd0) r = 32'b0;
		else           r = {1'b0, 8'd127 + {5'b0, p}, m[22:0]};
		return r;
	endfunction

	// float32 multiply, round to nearest even; operands are normal, zero, inf or NaN
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic               sr;
		logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
		logic [47:0]        p;
		logic signed [10:0] e;
		logic [23:0]        sig;
		logic               g, st;
		logic [30:0]        mag;
		logic [31:0]        r;
		sr     = a[31] ^ b[31];
		nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
		nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
		inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
		inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
		zero_a = (a[30:23] == 8'h00);
		zero_b = (b[30:23] == 8'h00);
		p   = {1'b1, a[22:0]} * {1'b1, b[22:0]};
		e   = $signed({3'b0, a[30:23]}) + $signed({3'b0, b[30:23]}) - 11'sd127;
		if (p[47]) begin
			sig = p[47:24];
			g   = p[23];
			st  = |p[22:0];
			e   = e + 11'sd1;
		end else begin
			sig = p[46:23];
			g   = p[22];
			st  = |p[21:0];
		end
		mag = {e[7:0], sig[22:0]};
		mag = mag + {30'b0, g & (st | sig[0])};
		if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) r = F32_QNAN;
		else if (inf_a || inf_b)    r = {sr, 8'hFF, 23'b0};
		else if (zero_a || zero_b)  r = {sr, 31'b0};
		else if (e >= 11'sd255)     r = {sr, 8'hFF, 23'b0};
		else if (e <= 11'sd0)       r = {sr, 31'b0};
		else                        r = {sr, mag};
		return r;
	endfunction

	// float32 add, first half: special cases, alignment and the wide add
	function automatic add_pre_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
		logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
		logic        swap;
		logic [31:0] big, sml;
		logic [7:0]  d;
		logic [26:0] big27, sm27, al, mask;
		logic        stk;
		add_pre_t    r;
		nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
		nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
		inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
		inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
		zero_a = (a[30:23] == 8'h00);
		zero_b = (b[30:23] == 8'h00);
		r = '0;
		swap  = b[30:0] > a[30:0];
		big   = swap ? b : a;
		sml   = swap ? a : b;
		d     = big[30:23] - sml[30:23];
		big27 = {1'b1, big[22:0], 3'b0};
		sm27  = {1'b1, sml[22:0], 3'b0};
		mask  = ~(27'h7FF_FFFF << d[4:0]);
		stk   = |(sm27 & mask);
		al    = sm27 >> d[4:0];
		al[0] = al[0] | stk;
		if (d >= 8'd27) al = 27'd1;
		r.sign = big[31];
		r.expo = big[30:23];
		if (big[31] == sml[31]) r.sum = {1'b0, big27} + {1'b0, al};
		else                    r.sum = {1'b0, big27} - {1'b0, al};
		// special operands bypass the arithmetic
		if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
			r.special     = 1'b1;
			r.special_val = F32_QNAN;
		end else if (inf_a) begin
			r.special     = 1'b1;
			r.special_val = a;
		end else if (inf_b) begin
			r.special     = 1'b1;
			r.special_val = b;
		end else if (zero_a && zero_b) begin
			r.special     = 1'b1;
			r.special_val = {a[31] & b[31], 31'b0};
		end else if (zero_a) begin
			r.special     = 1'b1;
			r.special_val = b;
		end else if (zero_b) begin
			r.special     = 1'b1;
			r.special_val = a;
		end
		return r;
	endfunction

	// float32 add, second half: normalise and round to nearest even
	function automatic logic [31:0] fadd_post(input add_pre_t p);
		logic [26:0]       n;
		logic signed [9:0] e;
		logic [4:0]        pos, lz;
		logic [23:0]       sig;
		logic              g, st;
		logic [30:0]       mag;
		logic [31:0]       r;
		pos = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (p.sum[i]) pos = 5'(i);
		end
		lz = 5'd26 - pos;
		if (p.sum[27]) begin
			n    = p.sum[27:1];
			n[0] = n[0] | p.sum[0];
			e    = $signed({2'b0, p.expo}) + 10'sd1;
		end else begin
			n = p.sum[26:0] << lz;
			e = $signed({2'b0, p.expo}) - $signed({5'b0, lz});
		end
		sig = n[26:3];
		g   = n[2];
		st  = |n[1:0];
		mag = {e[7:0], sig[22:0]};
		mag = mag + {30'b0, g & (st | sig[0])};
		if (p.special)               r = p.special_val;
		else if (p.sum == 28'd0)     r = 32'b0;
		else if (e >= 10'sd255)      r = {p.sign, 8'hFF, 23'b0};
		else if (e <= 10'sd0)        r = {p.sign, 31'b0};
		else                         r = {p.sign, mag};
		return r;
	endfunction

endpackage

[src/q5k_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by q5k_dpath for the packed scale and high-bit stores.
module q5k_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 12,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

[src/q5k_ctrl.sv]
// Sequencer for the Q5_K dequantizer: walks each quant byte through reads,
// the shared multiplier and the two-step adder. Depends on q5k_pkg.
module q5k_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        action,
	output logic              in_ready,
	input  q5k_pkg::status_t  status,
	output q5k_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_CAP_C,
		S_MUL_D,
		S_MUL_M,
		S_MUL_Q,
		S_ADD_PRE,
		S_ADD_POST
	} state_t;

	state_t state_q, state_d;
	logic   half_q, half_d;
	logic   rdy_q, rdy_d;

	// next state: only quant items leave idle
	always_comb begin
		state_d = state_q;
		half_d  = half_q;
		rdy_d   = rdy_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && rdy_q && (action == q5k_pkg::ACT_QUANT)) begin
					state_d = S_RD_A;
					half_d  = 1'b0;
					rdy_d   = 1'b0;
				end
			end
			S_RD_A:    state_d = S_RD_B;
			S_RD_B:    state_d = S_RD_C;
			S_RD_C:    state_d = S_CAP_C;
			S_CAP_C:   state_d = S_MUL_D;
			S_MUL_D:   state_d = S_MUL_M;
			S_MUL_M:   state_d = S_MUL_Q;
			S_MUL_Q:   state_d = S_ADD_PRE;
			S_ADD_PRE: state_d = S_ADD_POST;
			S_ADD_POST: begin
				if (status.out_free) begin
					if (half_q) begin
						state_d = S_IDLE;
						rdy_d   = 1'b1;
					end else begin
						state_d = S_RD_A;
						half_d  = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			half_q  <= 1'b0;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			half_q  <= half_d;
			rdy_q   <= rdy_d;
		end
	end

	// decode datapath commands from state
	always_comb begin
		cmd      = '0;
		cmd.half = half_q;
		cmd.rsel = q5k_pkg::RSEL_A;
		cmd.op   = q5k_pkg::OP_NONE;
		unique case (state_q)
			S_RD_A: begin
				cmd.sc_re  = 1'b1;
				cmd.rsel   = q5k_pkg::RSEL_A;
				cmd.cap_hb = 1'b1;
			end
			S_RD_B: begin
				cmd.sc_re = 1'b1;
				cmd.rsel  = q5k_pkg::RSEL_B;
				cmd.cap_a = 1'b1;
			end
			S_RD_C: begin
				cmd.sc_re = 1'b1;
				cmd.rsel  = q5k_pkg::RSEL_C;
				cmd.cap_b = 1'b1;
			end
			S_CAP_C:    cmd.cap_c = 1'b1;
			S_MUL_D:    cmd.op = q5k_pkg::OP_MUL_D;
			S_MUL_M:    cmd.op = q5k_pkg::OP_MUL_M;
			S_MUL_Q:    cmd.op = q5k_pkg::OP_MUL_Q;
			S_ADD_PRE:  cmd.op = q5k_pkg::OP_ADD_PRE;
			S_ADD_POST: begin
				if (status.out_free) cmd.op = q5k_pkg::OP_ADD_POST;
			end
			default: cmd.op = q5k_pkg::OP_NONE;
		endcase
	end

	assign in_ready = rdy_q;

endmodule

[src/q5k_dpath.sv]
// Datapath for the Q5_K dequantizer: stores, scale unpacking, shared float
// multiplier, two-step float adder and output register. Depends on q5k_pkg, q5k_ram.
module q5k_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       action,
	input  logic [6:0]       byte_index,
	input  logic [7:0]       byte_value,
	input  logic [15:0]      block_scale_half,
	input  logic [15:0]      block_min_half,
	input  q5k_pkg::cmd_t    cmd,
	output q5k_pkg::status_t status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       weight_index,
	output logic [31:0]      weight_bits,
	output logic             run_last,
	output logic             block_end
);

	localparam int SAW = $clog2(q5k_pkg::SCALE_BYTES);
	localparam int HAW = $clog2(q5k_pkg::HIGH_BYTES);

	logic [31:0] d_q, dm_q;
	logic [7:0]  qbyte_q;
	logic [1:0]  grp_q;
	logic [4:0]  lane_q;
	logic [7:0]  hb_q, a_q, b_q, c_q;
	logic [31:0] d1_q, m1_q, prod_q;
	q5k_pkg::add_pre_t pre_q;
	logic        out_valid_q;
	logic        half_q;
	logic [7:0]  widx_q;
	logic [31:0] wbits_q;

	logic            sc_we, hb_we, hb_re;
	logic [SAW-1:0]  sc_raddr;
	logic [7:0]      sc_rdata, hb_rdata;
	logic [2:0]      sub;
	logic [5:0]      sc, mn;
	logic            qhi;
	logic [4:0]      qv;
	logic [31:0]     mul_a, mul_b, mul_r;
	logic            load;

	// store writes and the high-bit read for an incoming quant byte
	assign sc_we = accept && (action == q5k_pkg::ACT_SCALE) &&
		(byte_index < 7'(q5k_pkg::SCALE_BYTES));
	assign hb_we = accept && (action == q5k_pkg::ACT_HIGH) &&
		(byte_index < 7'(q5k_pkg::HIGH_BYTES));
	assign hb_re = accept && (action == q5k_pkg::ACT_QUANT);

	q5k_ram #(.WIDTH(8), .DEPTH(q5k_pkg::SCALE_BYTES)) u_scale_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (byte_index[SAW-1:0]),
		.wdata (byte_value),
		.re    (cmd.sc_re),
		.raddr (sc_raddr),
		.rdata (sc_rdata)
	);

	q5k_ram #(.WIDTH(8), .DEPTH(q5k_pkg::HIGH_BYTES)) u_high_ram (
		.clk   (clk),
		.we    (hb_we),
		.waddr (byte_index[HAW-1:0]),
		.wdata (byte_value),
		.re    (hb_re),
		.raddr (byte_index[HAW-1:0]),
		.rdata (hb_rdata)
	);

	// latch header scales (widened) and the quant byte
	always_ff @(posedge clk) begin
		if (accept && (action == q5k_pkg::ACT_HEADER)) begin
			d_q  <= q5k_pkg::half_to_f32(block_scale_half);
			dm_q <= q5k_pkg::half_to_f32(block_min_half);
		end
		if (hb_re) begin
			qbyte_q <= byte_value;
			grp_q   <= byte_index[6:5];
			lane_q  <= byte_index[4:0];
		end
	end

	// scale byte addresses for sub-block j: A = j+4, B = j mod 4, C = j
	assign sub = {grp_q, cmd.half};
	always_comb begin
		case (cmd.rsel)
			q5k_pkg::RSEL_A: sc_raddr = SAW'({1'b0, sub} + 4'd4);
			q5k_pkg::RSEL_B: sc_raddr = SAW'({2'b0, sub[1:0]});
			q5k_pkg::RSEL_C: sc_raddr = SAW'({1'b0, sub});
			default:         sc_raddr = SAW'({1'b0, sub});
		endcase
	end

	// capture read data
	always_ff @(posedge clk) begin
		if (cmd.cap_hb) hb_q <= hb_rdata;
		if (cmd.cap_a)  a_q  <= sc_rdata;
		if (cmd.cap_b)  b_q  <= sc_rdata;
		if (cmd.cap_c)  c_q  <= sc_rdata;
	end

	// unpack 6-bit scale and min, form the 5-bit quant
	assign sc  = sub[2] ? {b_q[7:6], a_q[3:0]} : b_q[5:0];
	assign mn  = sub[2] ? {c_q[7:6], a_q[7:4]} : a_q[5:0];
	assign qhi = hb_q[sub];
	assign qv  = cmd.half ? {qhi, qbyte_q[7:4]} : {qhi, qbyte_q[3:0]};

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			q5k_pkg::OP_MUL_D: begin
				mul_a = d_q;
				mul_b = q5k_pkg::u6_to_f32(sc);
			end
			q5k_pkg::OP_MUL_M: begin
				mul_a = dm_q;
				mul_b = q5k_pkg::u6_to_f32(mn);
			end
			default: begin
				mul_a = d1_q;
				mul_b = q5k_pkg::u6_to_f32({1'b0, qv});
			end
		endcase
	end
	assign mul_r = q5k_pkg::fmul(mul_a, mul_b);

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			q5k_pkg::OP_MUL_D:   d1_q   <= mul_r;
			q5k_pkg::OP_MUL_M:   m1_q   <= mul_r;
			q5k_pkg::OP_MUL_Q:   prod_q <= mul_r;
			q5k_pkg::OP_ADD_PRE: pre_q  <= q5k_pkg::fadd_pre(prod_q, {~m1_q[31], m1_q[30:0]});
			default: ;
		endcase
	end

	// output register; hold the index with the weight so a new quant byte cannot disturb it
	assign load = (cmd.op == q5k_pkg::OP_ADD_POST);
	always_ff @(posedge clk) begin
		if (load) begin
			wbits_q <= q5k_pkg::fadd_post(pre_q);
			half_q  <= cmd.half;
			widx_q  <= {grp_q, cmd.half, lane_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign weight_bits  = wbits_q;
	assign run_last     = half_q;
	assign weight_index = widx_q;
	assign block_end    = (widx_q == 8'(q5k_pkg::BLOCK_WEIGHTS - 1));

endmodule

[src/q5k_superblock_dequantizer.sv]
// Q5_K super-block dequantizer, top level. Header, scale and high-bit items never stall
// the input. A quant byte occupies the block until its second weight is loaded into the
// output register. Its two weights are formed one after the other, paced by the one shared
// float multiplier (three uses per weight) and the single scale RAM read port.
// A stalled output delays the sequencer only while its one output register is full.
// Reset clears control state only; stored scales and high bits are undefined until written.
module q5k_superblock_dequantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [6:0]  byte_index,
	input  logic [7:0]  byte_value,
	input  logic [15:0] block_scale_half,
	input  logic [15:0] block_min_half,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  weight_index,
	output logic [31:0] weight_bits,
	output logic        run_last,
	output logic        block_end
);

	q5k_pkg::cmd_t    cmd;
	q5k_pkg::status_t status;
	logic             accept;

	assign accept = in_valid && in_ready;

	q5k_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	q5k_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.action           (action),
		.byte_index       (byte_index),
		.byte_value       (byte_value),
		.block_scale_half (block_scale_half),
		.block_min_half   (block_min_half),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.weight_index     (weight_index),
		.weight_bits      (weight_bits),
		.run_last         (run_last),
		.block_end        (block_end)
	);

	// a quant item makes the block busy
	a_quant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == q5k_pkg::ACT_QUANT)) |=> !in_ready)
		else $error("block still ready after a quant item");

	// store-only items never stall the input
	a_store_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action != q5k_pkg::ACT_QUANT)) |=> in_ready)
		else $error("ready dropped after a store item");

	// a result is only produced while a quant item is in flight
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

[tb/q5k_superblock_dequantizer_tb.sv]
// Testbench for q5k_superblock_dequantizer: directed and random items checked
// against a bit-exact predictor held in a small scoreboard class. Depends on q5k_pkg.
module q5k_superblock_dequantizer_tb;

	typedef struct {
		logic [7:0]  idx;
		logic [31:0] bits;
		logic        last;
		logic        bend;
	} weight_t;

	// predict the weights of each quant byte and check them in order
	class weight_scoreboard;
		logic [15:0] scale_h, min_h;
		logic [7:0]  sbytes [12];
		logic [7:0]  hbytes [32];
		weight_t     pending_q [$];
		int          errors = 0;
		int          checked = 0;

		function automatic longint unsigned half_units(logic [15:0] h);
			longint unsigned m;
			if (h[14:10] == 5'd0) m = h[9:0];
			else m = {54'd1, h[9:0]} << (h[14:10] - 1);
			return m;
		endfunction

		function automatic logic [31:0] fixed_to_f32(logic s, longint unsigned u);
			int              p, sh;
			longint unsigned m, rem, halfway;
			logic [7:0]      e;
			p = 0;
			for (int i = 0; i < 64; i++) if (u[i]) p = i;
			e = 8'(p + 103);
			if (p > 23) begin
				sh = p - 23;
				m = u >> sh;
				rem = u & ((64'd1 << sh) - 1);
				halfway = 64'd1 << (sh - 1);
				if (rem > halfway || (rem == halfway && m[0])) m = m + 1;
				if (m == (64'd1 << 24)) begin
					m = m >> 1;
					e = e + 8'd1;
				end
			end else begin
				m = u << (23 - p);
			end
			return {s, e, m[22:0]};
		endfunction

		function automatic logic [31:0] weight_of(int sub, int q);
			logic [5:0]      sc, mn;
			logic            sd, sm, dinf, dnan, minf, mnan, pinf, pnan, mi, mnn;
			longint          pv, mv, diff;
			if (sub < 4) begin
				sc = sbytes[sub][5:0];
				mn = sbytes[sub + 4][5:0];
			end else begin
				sc = {sbytes[sub - 4][7:6], sbytes[sub + 4][3:0]};
				mn = {sbytes[sub][7:6], sbytes[sub + 4][7:4]};
			end
			sd = scale_h[15];
			sm = min_h[15];
			dnan = scale_h[14:10] == 5'h1F && scale_h[9:0] != 0;
			dinf = scale_h[14:10] == 5'h1F && scale_h[9:0] == 0;
			mnan = min_h[14:10] == 5'h1F && min_h[9:0] != 0;
			minf = min_h[14:10] == 5'h1F && min_h[9:0] == 0;
			// infinities and NaN go their own way
			pnan = dnan || (dinf && (sc == 0 || q == 0));
			pinf = dinf && !pnan;
			mnn = mnan || (minf && mn == 0);
			mi = minf && !mnn;
			if (pnan || mnn) return q5k_pkg::F32_QNAN;
			if (pinf && mi) return (sd == sm) ? q5k_pkg::F32_QNAN : {sd, 8'hFF, 23'b0};
			if (pinf) return {sd, 8'hFF, 23'b0};
			if (mi) return {~sm, 8'hFF, 23'b0};
			// finite: exact in units of 2^-24, then one rounding
			pv = longint'(half_units(scale_h)) * sc * q;
			mv = longint'(half_units(min_h)) * mn;
			if (sd) pv = -pv;
			if (sm) mv = -mv;
			diff = pv - mv;
			if (diff == 0) begin
				if (pv == 0 && mv == 0) return {sd & ~sm, 31'b0};
				return 32'b0;
			end
			if (diff < 0) return fixed_to_f32(1'b1, longint'(-diff));
			return fixed_to_f32(1'b0, diff);
		endfunction

		function void note_item(q5k_pkg::action_t act, logic [6:0] bi, logic [7:0] bv,
		                        logic [15:0] sh, logic [15:0] mh);
			int      g, l, qlo, qhi;
			weight_t w;
			case (act)
				q5k_pkg::ACT_HEADER: begin
					scale_h = sh;
					min_h = mh;
				end
				q5k_pkg::ACT_SCALE: if (bi < q5k_pkg::SCALE_BYTES) sbytes[bi] = bv;
				q5k_pkg::ACT_HIGH: if (bi < q5k_pkg::HIGH_BYTES) hbytes[bi] = bv;
				default: begin
					g = bi >> 5;
					l = bi & 31;
					qlo = bv[3:0] + (hbytes[l][2 * g] ? 16 : 0);
					qhi = bv[7:4] + (hbytes[l][2 * g + 1] ? 16 : 0);
					w.idx = 8'(64 * g + l);
					w.bits = weight_of(2 * g, qlo);
					w.last = 1'b0;
					w.bend = (64 * g + l) == q5k_pkg::BLOCK_WEIGHTS - 1;
					pending_q.push_back(w);
					w.idx = 8'(64 * g + 32 + l);
					w.bits = weight_of(2 * g + 1, qhi);
					w.last = 1'b1;
					w.bend = (64 * g + 32 + l) == q5k_pkg::BLOCK_WEIGHTS - 1;
					pending_q.push_back(w);
				end
			endcase
		endfunction

		function void check_weight(logic [7:0] idx, logic [31:0] bits, logic last,
		                           logic bend);
			weight_t w;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected weight idx %0d bits %h", $time, idx, bits);
				errors++;
				return;
			end
			w = pending_q.pop_front();
			checked++;
			if (idx !== w.idx) begin
				$display("%0t: weight_index exp %0d got %0d", $time, w.idx, idx);
				errors++;
			end
			if (bits !== w.bits) begin
				$display("%0t: weight_bits idx %0d exp %h got %h", $time, w.idx, w.bits, bits);
				errors++;
			end
			if (last !== w.last) begin
				$display("%0t: run_last exp %b got %b", $time, w.last, last);
				errors++;
			end
			if (bend !== w.bend) begin
				$display("%0t: block_end exp %b got %b", $time, w.bend, bend);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = 2'd0;
	logic [6:0]  byte_index = 7'd0;
	logic [7:0]  byte_value = 8'd0;
	logic [15:0] block_scale_half = 16'd0;
	logic [15:0] block_min_half = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  weight_index;
	logic [31:0] weight_bits;
	logic        run_last;
	logic        block_end;

	weight_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;

	q5k_superblock_dequantizer u_top (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL q5k_superblock_dequantizer");
			$finish;
		end
	end

	// check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_weight(weight_index, weight_bits, run_last, block_end);
	end

	// receiver: random stalls, with one long hold-off to back up the block
	initial begin
		int hold;
		bit long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_done && cycles >= 3000) begin
				long_done = 1'b1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			hold = $urandom_range(0, 99);
			if (hold < 60) out_ready = 1'b1;
			else if (hold < 95) out_ready = 1'b0;
			else begin
				out_ready = 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	// offer one item, hold it until accepted, then maybe idle
	task automatic send_item(q5k_pkg::action_t act, logic [6:0] bi, logic [7:0] bv,
	                         logic [15:0] sh, logic [15:0] mh);
		int gap;
		action = act;
		byte_index = bi;
		byte_value = bv;
		block_scale_half = sh;
		block_min_half = mh;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, bi, bv, sh, mh);
		items_sent++;
		@(negedge clk);
		gap = $urandom_range(0, 99);
		if (gap >= 55) begin
			in_valid = 1'b0;
			if (gap < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
			else repeat ($urandom_range(10, 30)) @(negedge clk);
		end
	endtask

	task automatic send_quant(logic [6:0] bi, logic [7:0] bv);
		send_item(q5k_pkg::ACT_QUANT, bi, bv, 16'($urandom), 16'($urandom));
	endtask

	task automatic load_tables();
		for (int i = 0; i < q5k_pkg::SCALE_BYTES; i++)
			send_item(q5k_pkg::ACT_SCALE, 7'(i), 8'($urandom), 16'($urandom),
			          16'($urandom));
		for (int i = 0; i < q5k_pkg::HIGH_BYTES; i++)
			send_item(q5k_pkg::ACT_HIGH, 7'(i), 8'($urandom), 16'($urandom),
			          16'($urandom));
	endtask

	initial begin
		logic [15:0] halves [10];
		int          pick, t;
		halves = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h7BFF,
		           16'hFBFF, 16'h7C00, 16'hFC00, 16'h7E01, 16'h3C00};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every stored value before any quant byte reads it
		send_item(q5k_pkg::ACT_HEADER, 7'd0, 8'd0, 16'h3C00, 16'h3800);
		load_tables();

		// directed: field extremes, ignored indexes, special halves
		send_item(q5k_pkg::ACT_SCALE, 7'd127, 8'h00, 16'hFFFF, 16'hFFFF);
		send_item(q5k_pkg::ACT_HIGH, 7'd127, 8'hFF, 16'h0000, 16'h0000);
		send_item(q5k_pkg::ACT_SCALE, 7'd11, 8'hFF, 16'h0000, 16'h0000);
		send_item(q5k_pkg::ACT_HIGH, 7'd0, 8'hFF, 16'h0000, 16'h0000);
		send_quant(7'd0, 8'h00);
		send_quant(7'd127, 8'hFF);
		for (int i = 0; i < 10; i++) begin
			send_item(q5k_pkg::ACT_HEADER, 7'd0, 8'd0, halves[i], halves[9 - i]);
			send_quant(7'($urandom), 8'($urandom));
		end
		send_item(q5k_pkg::ACT_SCALE, 7'd0, 8'h00, 16'h0, 16'h0);
		send_item(q5k_pkg::ACT_SCALE, 7'd4, 8'h00, 16'h0, 16'h0);
		send_item(q5k_pkg::ACT_HEADER, 7'd0, 8'd0, 16'h7C00, 16'hFC00);
		send_quant(7'd0, 8'h00);
		send_quant(7'd0, 8'h5A);

		// well-formed blocks: header, tables, then all quant bytes in order
		for (int b = 0; b < 2; b++) begin
			send_item(q5k_pkg::ACT_HEADER, 7'd0, 8'd0,
			          16'($urandom_range(16'h0400, 16'h5000)),
			          16'($urandom_range(0, 16'h4800)));
			load_tables();
			for (int i = 0; i < 128; i++) send_quant(7'(i), 8'($urandom));
		end

		// random mix; quant bytes dominate
		for (int n = 0; n < 80; n++) begin
			pick = $urandom_range(0, 99);
			t = $urandom_range(0, 9);
			if (pick < 8)
				send_item(q5k_pkg::ACT_HEADER, 7'($urandom), 8'($urandom),
				          (t == 0) ? halves[$urandom_range(0, 9)] : 16'($urandom),
				          (t == 1) ? halves[$urandom_range(0, 9)] : 16'($urandom));
			else if (pick < 18)
				send_item(q5k_pkg::ACT_SCALE, 7'((t < 8) ? $urandom_range(0, 11) : $urandom),
				          8'($urandom), 16'($urandom), 16'($urandom));
			else if (pick < 28)
				send_item(q5k_pkg::ACT_HIGH, 7'((t < 8) ? $urandom_range(0, 31) : $urandom),
				          8'($urandom), 16'($urandom), 16'($urandom));
			else
				send_quant(7'($urandom), 8'($urandom));
		end
		in_valid = 1'b0;

		// drain, then allow the block's latency to pass
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("Sent %0d items and checked %0d weights over %0d cycles.",
		         items_sent, sb.checked, cycles);
		$display("Covered special halves, ignored indexes, full blocks and a long stall.");
		if (sb.errors == 0) begin
			$display("PASS q5k_superblock_dequantizer");
		end else begin
			$display("FAIL q5k_superblock_dequantizer");
		end
		$finish;
	end
endmodule

[q5k_superblock_dequantizer.f]
src/q5k_pkg.sv
src/q5k_ram.sv
src/q5k_ctrl.sv
src/q5k_dpath.sv
src/q5k_superblock_dequantizer.sv
tb/q5k_superblock_dequantizer_tb.sv
